FILE: src/cfr_pkg.sv
package cfr_pkg;

   typedef enum logic [2:0] {
      OP_ALLOC  = 3'd0,
      OP_ACCESS = 3'd1,
      OP_PIN    = 3'd2,
      OP_UNPIN  = 3'd3,
      OP_EVICT  = 3'd4,
      OP_FREE   = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_VICTIM = 2'd1,
      ST_BAD       = 2'd2
   } status_type;

   localparam int FLAG_USER = 0;
   localparam int FLAG_FILE = 1;
   localparam int FLAG_SWAP = 2;

   typedef struct packed {
      logic [2:0] opcode;
      logic [5:0] slot;
      logic       user_page;
      logic       file_mapped;
      logic       swap_backed;
      logic       write_access;
   } req_type;

   typedef struct packed {
      logic [5:0] granted_slot;
      logic       victim_valid;
      logic [5:0] victim_slot;
      logic       victim_writeback;
      logic       victim_to_file;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_DECIDE,
      S_SCAN,
      S_SWEEP_RD,
      S_SWEEP_EV,
      S_DROP_RD,
      S_DROP,
      S_LINK_RD,
      S_LINK,
      S_SEARCH,
      S_DONE
   } state_type;

endpackage

FILE: src/cfr_if.sv
interface cfr_req_if;
   import cfr_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cfr_rsp_if;
   import cfr_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/cfr_table.sv
module cfr_table #(
   parameter int FRAMES   = 64,
   parameter int PIN_BITS = 8,
   parameter int SW       = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [SW-1:0]       rd_addr,
   output logic                rd_valid,
   output logic [PIN_BITS-1:0] rd_pin,
   output logic                rd_acc,
   output logic                rd_dirty,
   output logic [2:0]          rd_flags,
   output logic [SW-1:0]       rd_next,
   output logic [SW-1:0]       rd_prev,
   input  logic                wr_en,
   input  logic [SW-1:0]       wr_addr,
   input  logic                wr_valid,
   input  logic [PIN_BITS-1:0] wr_pin,
   input  logic                wr_acc,
   input  logic                wr_dirty,
   input  logic [2:0]          wr_flags,
   input  logic                ln_en,
   input  logic [SW-1:0]       ln_addr,
   input  logic                ln_wr_next,
   input  logic [SW-1:0]       ln_next,
   input  logic                ln_wr_prev,
   input  logic [SW-1:0]       ln_prev
);
   localparam int MW = PIN_BITS + 5;

   logic [FRAMES-1:0] valid_ff;
   logic [MW-1:0]     meta_mem [FRAMES];
   logic [SW-1:0]     next_mem [FRAMES];
   logic [SW-1:0]     prev_mem [FRAMES];
   logic [MW-1:0]     meta_q_ff;
   logic [SW-1:0]     next_q_ff;
   logic [SW-1:0]     prev_q_ff;
   logic              valid_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= wr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         meta_mem[wr_addr] <= {wr_pin, wr_acc, wr_dirty, wr_flags};
      end
      if (ln_en && ln_wr_next) begin
         next_mem[ln_addr] <= ln_next;
      end
      if (ln_en && ln_wr_prev) begin
         prev_mem[ln_addr] <= ln_prev;
      end
      meta_q_ff  <= meta_mem[rd_addr];
      next_q_ff  <= next_mem[rd_addr];
      prev_q_ff  <= prev_mem[rd_addr];
      valid_q_ff <= valid_ff[rd_addr];
   end

   assign rd_valid = valid_q_ff;
   assign rd_pin   = meta_q_ff[MW-1:5];
   assign rd_acc   = meta_q_ff[4];
   assign rd_dirty = meta_q_ff[3];
   assign rd_flags = meta_q_ff[2:0];
   assign rd_next  = next_q_ff;
   assign rd_prev  = prev_q_ff;
endmodule

FILE: src/clock_frame_replacement_core.sv
// channel  direction  payload
// req      in         opcode, slot, page attributes, write flag
// rsp      out        granted slot, victim report, status
// access, pin, unpin: the frame is read, then updated and the result reported
// free and evict: read, decide, then unlink with one or two link writes
// allocate with a free slot: scan from slot 0 for the lowest free one, then link it in
// allocate on a full ring: clock sweep from the hand (or head), up to 2*FRAMES entries
// one item at a time; reset clears valid bits at once, no clearing pass
// rsp stalls hold the result in its register; req is taken only when idle
module clock_frame_replacement_core #(
   parameter int FRAMES   = 64,
   parameter int PIN_BITS = 8
) (
   input  logic      clock,
   input  logic      reset,
   cfr_req_if.sink   req,
   cfr_rsp_if.source rsp
);
   import cfr_pkg::*;

   localparam int SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CW = $clog2(FRAMES + 1);
   localparam int KW = $clog2(2 * FRAMES + 1);
   localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] head_ff, head_in, tail_ff, tail_in, hand_ff, hand_in;
   logic          hand_set_ff, hand_set_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] cur_ff, cur_in;
   logic [KW-1:0] k_ff, k_in;
   logic [SW-1:0] tgt_ff, tgt_in;
   logic [SW-1:0] nxt_ff, nxt_in, prv_ff, prv_in;
   logic [1:0]    step_ff, step_in;
   logic          alloc_ff, alloc_in;

   logic [SW-1:0]       rd_addr;
   logic                rd_valid, rd_acc, rd_dirty;
   logic [PIN_BITS-1:0] rd_pin;
   logic [2:0]          rd_flags;
   logic [SW-1:0]       rd_next, rd_prev;
   logic                wr_en, wr_valid, wr_acc, wr_dirty;
   logic [SW-1:0]       wr_addr;
   logic [PIN_BITS-1:0] wr_pin;
   logic [2:0]          wr_flags;
   logic                ln_en, ln_wr_next, ln_wr_prev;
   logic [SW-1:0]       ln_addr, ln_next, ln_prev;
   logic                slot_ok, wb;

   cfr_table #(.FRAMES(FRAMES), .PIN_BITS(PIN_BITS), .SW(SW)) u_table (
      .clock, .reset, .rd_addr, .rd_valid, .rd_pin, .rd_acc, .rd_dirty, .rd_flags,
      .rd_next, .rd_prev, .wr_en, .wr_addr, .wr_valid, .wr_pin, .wr_acc, .wr_dirty,
      .wr_flags, .ln_en, .ln_addr, .ln_wr_next, .ln_next, .ln_wr_prev, .ln_prev
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         hand_ff      <= '0;
         hand_set_ff  <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         hand_ff      <= hand_in;
         hand_set_ff  <= hand_set_in;
         count_ff     <= count_in;
      end
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      cur_ff   <= cur_in;
      k_ff     <= k_in;
      tgt_ff   <= tgt_in;
      nxt_ff   <= nxt_in;
      prv_ff   <= prv_in;
      step_ff  <= step_in;
      alloc_ff <= alloc_in;
   end

   assign req.ready     = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.payload   = rsp_ff;
   assign slot_ok       = ({26'd0, req_ff.slot} < 32'(FRAMES));
   assign wb            = rd_dirty || rd_flags[FLAG_SWAP];

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      hand_in      = hand_ff;
      hand_set_in  = hand_set_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      tgt_in       = tgt_ff;
      nxt_in       = nxt_ff;
      prv_in       = prv_ff;
      step_in      = step_ff;
      alloc_in     = alloc_ff;
      rd_addr      = cur_ff;
      wr_en        = 1'b0;
      wr_addr      = tgt_ff;
      wr_valid     = 1'b1;
      wr_pin       = rd_pin;
      wr_acc       = rd_acc;
      wr_dirty     = rd_dirty;
      wr_flags     = rd_flags;
      ln_en        = 1'b0;
      ln_addr      = tgt_ff;
      ln_wr_next   = 1'b0;
      ln_next      = tgt_ff;
      ln_wr_prev   = 1'b0;
      ln_prev      = tgt_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               req_in   = req.payload;
               rsp_in   = '0;
               alloc_in = 1'b0;
               cur_in   = SW'(req.payload.slot);
               tgt_in   = SW'(req.payload.slot);
               if (req.payload.opcode == OP_ALLOC) begin
                  alloc_in = 1'b1;
                  k_in     = '0;
                  if (count_ff < CW'(FRAMES)) begin
                     cur_in   = '0;
                     state_in = S_SEARCH;
                  end else begin
                     cur_in      = hand_set_ff ? hand_ff : head_ff;
                     hand_set_in = 1'b1;
                     state_in    = S_SWEEP_RD;
                  end
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_SEARCH: begin
            rd_addr  = cur_ff;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (!rd_valid) begin
               tgt_in   = cur_ff;
               state_in = S_LINK_RD;
            end else begin
               cur_in   = cur_ff + SW'(1);
               rd_addr  = cur_ff + SW'(1);
               state_in = S_SCAN;
            end
         end
         S_SWEEP_RD: begin
            rd_addr  = cur_ff;
            state_in = S_SWEEP_EV;
         end
         S_SWEEP_EV: begin
            if (k_ff >= KW'({count_ff, 1'b0})) begin
               hand_in        = cur_ff;
               rsp_in.status  = ST_NO_VICTIM;
               state_in       = S_DONE;
            end else if (rd_flags[FLAG_USER] && rd_pin == '0 && !rd_acc) begin
               hand_in                 = cur_ff;
               tgt_in                  = cur_ff;
               rsp_in.victim_valid     = 1'b1;
               rsp_in.victim_slot      = 6'(cur_ff);
               rsp_in.victim_writeback = wb;
               rsp_in.victim_to_file   = wb && rd_flags[FLAG_FILE];
               nxt_in                  = rd_next;
               prv_in                  = rd_prev;
               state_in                = S_DROP;
               step_in                 = 2'd0;
            end else begin
               if (rd_flags[FLAG_USER] && rd_pin == '0) begin
                  wr_en   = 1'b1;
                  wr_addr = cur_ff;
                  wr_acc  = 1'b0;
               end
               k_in     = k_ff + KW'(1);
               cur_in   = (cur_ff == tail_ff) ? head_ff : rd_next;
               state_in = S_SWEEP_RD;
            end
         end
         S_READ: begin
            rd_addr  = tgt_ff;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_DONE;
            if (req_ff.opcode > OP_FREE || !slot_ok || !rd_valid) begin
               rsp_in.status = ST_BAD;
            end else begin
               case (req_ff.opcode)
                  OP_ACCESS: begin
                     wr_en  = 1'b1;
                     wr_acc = 1'b1;
                     if (req_ff.write_access) begin
                        wr_dirty = 1'b1;
                     end
                  end
                  OP_PIN: begin
                     if (rd_pin == PIN_MAX) begin
                        rsp_in.status = ST_BAD;
                     end else begin
                        wr_en  = 1'b1;
                        wr_pin = rd_pin + PIN_BITS'(1);
                     end
                  end
                  OP_UNPIN: begin
                     if (rd_pin == '0) begin
                        rsp_in.status = ST_BAD;
                     end else begin
                        wr_en  = 1'b1;
                        wr_pin = rd_pin - PIN_BITS'(1);
                     end
                  end
                  OP_EVICT: begin
                     if (rd_pin != '0 || !rd_flags[FLAG_USER]) begin
                        rsp_in.status = ST_BAD;
                     end else begin
                        rsp_in.victim_valid     = 1'b1;
                        rsp_in.victim_slot      = 6'(tgt_ff);
                        rsp_in.victim_writeback = wb;
                        rsp_in.victim_to_file   = wb && rd_flags[FLAG_FILE];
                        nxt_in                  = rd_next;
                        prv_in                  = rd_prev;
                        step_in                 = 2'd0;
                        state_in                = S_DROP;
                     end
                  end
                  OP_FREE: begin
                     if (rd_pin != '0) begin
                        rsp_in.status = ST_BAD;
                     end else begin
                        nxt_in   = rd_next;
                        prv_in   = rd_prev;
                        step_in  = 2'd0;
                        state_in = S_DROP;
                     end
                  end
                  default: begin
                     rsp_in.status = ST_BAD;
                  end
               endcase
            end
         end
         S_DROP: begin
            // unlink tgt, nxt/prv hold its neighbours
            if (hand_set_ff && hand_ff == tgt_ff) begin
               if (count_ff > CW'(1)) begin
                  hand_in = (tgt_ff == tail_ff) ? head_ff : nxt_ff;
               end else begin
                  hand_set_in = 1'b0;
                  hand_in     = '0;
               end
            end
            wr_en    = 1'b1;
            wr_valid = 1'b0;
            count_in = count_ff - CW'(1);
            if (count_ff == CW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else begin
               if (tgt_ff == head_ff) begin
                  head_in = nxt_ff;
               end else begin
                  ln_en      = 1'b1;
                  ln_addr    = prv_ff;
                  ln_wr_next = 1'b1;
                  ln_next    = nxt_ff;
               end
               if (tgt_ff == tail_ff) begin
                  tail_in = prv_ff;
               end else begin
                  ln_en      = 1'b1;
                  ln_addr    = (tgt_ff == head_ff) ? nxt_ff : ln_addr;
                  ln_wr_prev = 1'b1;
                  ln_prev    = prv_ff;
               end
               if (tgt_ff != head_ff && tgt_ff != tail_ff) begin
                  // both neighbours need a write: second one next cycle
                  ln_wr_prev = 1'b0;
                  step_in    = 2'd1;
               end
            end
            state_in = (step_in == 2'd1) ? S_DROP_RD : (alloc_ff ? S_LINK_RD : S_DONE);
         end
         S_DROP_RD: begin
            ln_en      = 1'b1;
            ln_addr    = nxt_ff;
            ln_wr_prev = 1'b1;
            ln_prev    = prv_ff;
            step_in    = 2'd0;
            state_in   = alloc_ff ? S_LINK_RD : S_DONE;
         end
         S_LINK_RD: begin
            rd_addr  = hand_ff;
            state_in = S_LINK;
            step_in  = 2'd0;
         end
         S_LINK: begin
            // rd_prev is prev of the hand frame
            wr_en    = 1'b1;
            wr_addr  = tgt_ff;
            wr_valid = 1'b1;
            wr_pin   = PIN_BITS'(1);
            wr_acc   = 1'b0;
            wr_dirty = 1'b0;
            wr_flags = {req_ff.swap_backed, req_ff.file_mapped, req_ff.user_page};
            ln_en    = 1'b1;
            ln_addr  = tgt_ff;
            if (step_ff == 2'd0) begin
               ln_wr_next = 1'b1;
               ln_wr_prev = 1'b1;
               if (count_ff == '0) begin
                  ln_next  = tgt_ff;
                  ln_prev  = tgt_ff;
                  head_in  = tgt_ff;
                  tail_in  = tgt_ff;
                  step_in  = 2'd3;
               end else if (!hand_set_ff) begin
                  ln_next  = tgt_ff;
                  ln_prev  = tail_ff;
                  step_in  = 2'd1;
               end else begin
                  ln_next = hand_ff;
                  if (hand_ff == head_ff) begin
                     ln_prev = tgt_ff;
                     head_in = tgt_ff;
                     step_in = 2'd2;
                  end else begin
                     ln_prev = rd_prev;
                     prv_in  = rd_prev;
                     step_in = 2'd1;
                  end
               end
            end else if (step_ff == 2'd1) begin
               wr_en      = 1'b0;
               ln_wr_next = 1'b1;
               if (!hand_set_ff) begin
                  ln_addr = tail_ff;
                  ln_next = tgt_ff;
                  tail_in = tgt_ff;
                  step_in = 2'd3;
               end else begin
                  ln_addr = prv_ff;
                  ln_next = tgt_ff;
                  step_in = 2'd2;
               end
            end else begin
               wr_en      = 1'b0;
               ln_addr    = hand_ff;
               ln_wr_prev = 1'b1;
               ln_prev    = tgt_ff;
               step_in    = 2'd3;
            end
            if (step_in == 2'd3) begin
               count_in            = count_ff + CW'(1);
               rsp_in.granted_slot = 6'(tgt_ff);
               state_in            = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule
